/* src/spl_pkg.sv */
// spl_pkg: shared types, codes and constants of the stepper position loop
// used by the channel interfaces and by every module under src

package spl_pkg;

    // machine geometry
    localparam int unsigned ENCODER_COUNTS = 4096;
    localparam int unsigned MOTOR_STEPS    = 3200;
    localparam int unsigned MICROSTEP      = 16;

    localparam int unsigned SETTLE_LIMIT   = 3;
    localparam int unsigned MAX_BURST      = (8 * MICROSTEP) / 16;
    localparam int unsigned WINDOW_LIMIT   = 64;
    localparam int          CONFIRM_COUNTS = 2;
    localparam int unsigned REVERSE_LIMIT  = 64;
    localparam int          REVERSE_COUNTS = 3;
    localparam int unsigned ACC_MAX        = 65535;

    // error tiers and step rates
    localparam int unsigned TIER4_ERR = 800;
    localparam int unsigned TIER3_ERR = 200;
    localparam int unsigned TIER2_ERR = 50;
    localparam int unsigned TIER1_ERR = 15;
    localparam int unsigned RATE_T4   = 8000;
    localparam int unsigned RATE_T3   = 5000;
    localparam int unsigned RATE_T2   = 2500;
    localparam int unsigned RATE_T1   = 1200;
    localparam int unsigned RATE_T0   = 800;

    // any error above this magnitude gives the full burst
    localparam int unsigned CLAMP_MAG = (MAX_BURST * ENCODER_COUNTS) / MOTOR_STEPS;
    localparam int unsigned MAGC_W    = $clog2(CLAMP_MAG + 2);
    localparam int unsigned SUM_W     = $clog2((MAX_BURST + 1) * ENCODER_COUNTS) + 1;

    localparam int unsigned TOL_W       = 10;
    localparam int unsigned TOL_RESET   = 4;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam int unsigned CFG_INDEX_W = 1;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_TARGET = 3'd1,
        MODE_STOP   = 3'd2,
        MODE_CLEAR  = 3'd3,
        MODE_ZERO   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        FAULT_NONE       = 2'd0,
        FAULT_NO_ENCODER = 2'd1,
        FAULT_DIRECTION  = 2'd2,
        FAULT_DRIVER     = 2'd3
    } fault_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } dir_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POS_DIR   = 1'd0,
        CFG_TOLERANCE = 1'd1
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] encoder_count;
        logic               motor_busy;
        logic               driver_reject;
        logic signed [31:0] new_target;
    } in_item_t;

    typedef struct packed {
        logic        start_burst;
        logic [7:0]  burst_steps;
        logic [12:0] step_rate_hz;
        logic        dir_level;
        logic        stop_motor;
        logic        zero_encoder;
        logic        on_target;
        logic        loop_active;
        logic [1:0]  fault_code;
        logic        accepted;
    } out_item_t;

    // register settings seen by the controller
    typedef struct packed {
        logic             pos_dir_level;
        logic [TOL_W-1:0] tolerance;
    } cfg_t;

endpackage

/* src/spl_if.sv */
// spl_in_if and spl_out_if: valid/ready channels for command and result items
// depends on spl_pkg for the payload types

interface spl_in_if;
    import spl_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spl_out_if;
    import spl_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/stepper_position_loop.sv */
// stepper_position_loop: top level of the closed-loop stepper position controller
// depends on spl_pkg, spl_if, spl_in_stage, spl_ctrl and spl_out_stage

// One command item (tick, set target, stop, clear fault, set zero) is taken per
// clock. An item is held in the input register, evaluated combinationally
// against the loop state, and its result is registered and offered on the
// result channel; the loop state update in the controller is the only
// recurrence, so throughput is one item per clock as long as results are
// drained. Register writes take effect at the next clock and must be made
// with no item in flight.

module stepper_position_loop (
    input  logic                            clk,
    input  logic                            rst_n,
    spl_in_if.sink                          cmd,
    spl_out_if.source                       result,
    input  logic                            cfg_wr_en,
    input  logic [spl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import spl_pkg::*;

    logic      s1_valid;
    in_item_t  s1_item;
    out_item_t res;
    logic      can_load;
    logic      advance;

    assign advance = s1_valid && can_load;

    spl_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    spl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (advance),
        .item      (s1_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .res       (res)
    );

    spl_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .load     (advance),
        .res      (res),
        .can_load (can_load)
    );

endmodule

/* src/spl_in_stage.sv */
// spl_in_stage: input register of the command channel
// depends on spl_pkg and spl_in_if

module spl_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    spl_in_if.sink            cmd,
    input  logic              advance,
    output logic              s1_valid,
    output spl_pkg::in_item_t s1_item
);
    import spl_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign cmd.ready = !valid_reg || advance;
    assign s1_valid  = valid_reg;
    assign s1_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg <= cmd.data;
        end
    end

endmodule

/* src/spl_burst_calc.sv */
// spl_burst_calc: step count and step rate of a burst from the error magnitude
// depends on spl_pkg

module spl_burst_calc (
    input  logic [31:0] mag,
    output logic [7:0]  steps,
    output logic [12:0] rate
);
    import spl_pkg::*;

    logic [MAGC_W-1:0] mag_c;
    logic [SUM_W-1:0]  prod;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  quo;

    always_comb
    begin
        mag_c = mag[MAGC_W-1:0];
        prod  = SUM_W'(mag_c) * SUM_W'(MOTOR_STEPS);
        sum   = prod + SUM_W'(ENCODER_COUNTS - 1);
        // encoder resolution is a power of two, so this is a shift
        quo   = sum / SUM_W'(ENCODER_COUNTS);
        if (mag > 32'(CLAMP_MAG))
        begin
            steps = 8'(MAX_BURST);
        end
        else if (quo == '0)
        begin
            steps = 8'd1;
        end
        else if (quo > SUM_W'(MAX_BURST))
        begin
            steps = 8'(MAX_BURST);
        end
        else
        begin
            steps = quo[7:0];
        end
    end

    always_comb
    begin
        if (mag > 32'(TIER4_ERR))
        begin
            rate = 13'(RATE_T4);
        end
        else if (mag > 32'(TIER3_ERR))
        begin
            rate = 13'(RATE_T3);
        end
        else if (mag > 32'(TIER2_ERR))
        begin
            rate = 13'(RATE_T2);
        end
        else if (mag > 32'(TIER1_ERR))
        begin
            rate = 13'(RATE_T1);
        end
        else
        begin
            rate = 13'(RATE_T0);
        end
    end

endmodule

/* src/spl_ctrl.sv */
// spl_ctrl: loop state, register settings and the per-item control rule
// depends on spl_pkg and spl_burst_calc

module spl_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              commit,
    input  spl_pkg::in_item_t                 item,
    input  logic                              cfg_wr_en,
    input  logic [spl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [spl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output spl_pkg::out_item_t                res
);
    import spl_pkg::*;

    localparam logic signed [32:0] MV_CONFIRM = 33'(CONFIRM_COUNTS);
    localparam logic signed [32:0] MV_REVERSE = 33'(REVERSE_COUNTS);

    cfg_t               cfg_reg;
    logic signed [31:0] target_reg, target_next;
    logic               active_reg, active_next;
    logic               reached_reg, reached_next;
    fault_t             fault_reg, fault_next;
    logic [1:0]         settle_reg, settle_next;
    logic               pending_reg, pending_next;
    dir_t               exp_dir_reg, exp_dir_next;
    logic [15:0]        win_steps_reg, win_steps_next;
    logic [15:0]        rev_total_reg, rev_total_next;
    logic signed [31:0] win_start_reg, win_start_next;

    logic signed [32:0] mv;
    logic signed [32:0] err;
    logic signed [32:0] err_abs;
    logic signed [32:0] delta;
    logic signed [32:0] tol_s;
    logic [31:0]        mag;
    logic [7:0]         steps;
    logic [12:0]        rate;
    logic [15:0]        win_base;
    dir_t               want;
    logic               dir_bit;

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > 17'(ACC_MAX)) ? 16'(ACC_MAX) : s[15:0];
    endfunction

    spl_burst_calc u_burst (
        .mag   (mag),
        .steps (steps),
        .rate  (rate)
    );

    always_comb
    begin
        mv      = {item.encoder_count[31], item.encoder_count}
                - {win_start_reg[31], win_start_reg};
        err     = {target_reg[31], target_reg} - {item.encoder_count[31], item.encoder_count};
        err_abs = err[32] ? -err : err;
        mag     = err_abs[31:0];
        delta   = {item.new_target[31], item.new_target} - {target_reg[31], target_reg};
        tol_s   = {23'd0, cfg_reg.tolerance};
        want    = err[32] ? DIR_NEG : DIR_POS;
        dir_bit = err[32] ? !cfg_reg.pos_dir_level : cfg_reg.pos_dir_level;
    end

    always_comb
    begin
        target_next    = target_reg;
        active_next    = active_reg;
        reached_next   = reached_reg;
        fault_next     = fault_reg;
        settle_next    = settle_reg;
        pending_next   = pending_reg;
        exp_dir_next   = exp_dir_reg;
        win_steps_next = win_steps_reg;
        rev_total_next = rev_total_reg;
        win_start_next = win_start_reg;
        win_base       = '0;
        res            = '0;

        unique case (item.mode)
            MODE_TICK:
            begin
                if (!item.motor_busy)
                begin
                    // judge the outcome of the previous burst
                    if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        if ((exp_dir_reg == DIR_POS && mv >= MV_CONFIRM) ||
                            (exp_dir_reg == DIR_NEG && mv <= -MV_CONFIRM))
                        begin
                            win_steps_next = '0;
                            rev_total_next = '0;
                        end
                        else if ((exp_dir_reg == DIR_POS && mv <= -MV_REVERSE) ||
                                 (exp_dir_reg == DIR_NEG && mv >= MV_REVERSE))
                        begin
                            rev_total_next = sat_add(rev_total_reg, win_steps_reg);
                            win_steps_next = '0;
                            exp_dir_next   = DIR_NONE;
                            if (rev_total_next >= 16'(REVERSE_LIMIT))
                            begin
                                fault_next     = FAULT_DIRECTION;
                                active_next    = 1'b0;
                                win_steps_next = '0;
                                rev_total_next = '0;
                                reached_next   = 1'b0;
                                res.stop_motor = 1'b1;
                            end
                        end
                        else if (win_steps_reg >= 16'(WINDOW_LIMIT))
                        begin
                            fault_next     = FAULT_NO_ENCODER;
                            active_next    = 1'b0;
                            win_steps_next = '0;
                            rev_total_next = '0;
                            reached_next   = 1'b0;
                            res.stop_motor = 1'b1;
                        end
                    end

                    if (active_next && fault_next == FAULT_NONE)
                    begin
                        if (mag <= {22'd0, cfg_reg.tolerance})
                        begin
                            if (settle_reg < 2'(SETTLE_LIMIT))
                            begin
                                settle_next = settle_reg + 2'd1;
                            end
                            if (settle_next >= 2'(SETTLE_LIMIT))
                            begin
                                reached_next = 1'b1;
                            end
                        end
                        else
                        begin
                            settle_next  = '0;
                            reached_next = 1'b0;
                            if (item.driver_reject)
                            begin
                                fault_next     = FAULT_DRIVER;
                                active_next    = 1'b0;
                                pending_next   = 1'b0;
                                win_steps_next = '0;
                                rev_total_next = '0;
                                res.stop_motor = 1'b1;
                            end
                            else
                            begin
                                res.start_burst  = 1'b1;
                                res.burst_steps  = steps;
                                res.step_rate_hz = rate;
                                res.dir_level    = dir_bit;
                                // new window when idle or the direction flips
                                if (win_steps_next == '0 || exp_dir_next != want)
                                begin
                                    win_start_next = item.encoder_count;
                                    exp_dir_next   = want;
                                    win_base       = '0;
                                end
                                else
                                begin
                                    win_base = win_steps_next;
                                end
                                win_steps_next = sat_add(win_base, {8'd0, steps});
                                pending_next   = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_TARGET:
            begin
                if (fault_reg == FAULT_NONE)
                begin
                    if (!active_reg || delta > tol_s || delta < -tol_s)
                    begin
                        reached_next = 1'b0;
                        settle_next  = '0;
                    end
                    target_next  = item.new_target;
                    active_next  = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            MODE_STOP:
            begin
                res.stop_motor = 1'b1;
                active_next    = 1'b0;
                pending_next   = 1'b0;
                win_steps_next = '0;
                rev_total_next = '0;
                reached_next   = 1'b0;
            end
            MODE_CLEAR:
            begin
                res.stop_motor = 1'b1;
                target_next    = item.encoder_count;
                active_next    = 1'b0;
                pending_next   = 1'b0;
                win_steps_next = '0;
                rev_total_next = '0;
                reached_next   = 1'b1;
                fault_next     = FAULT_NONE;
            end
            MODE_ZERO:
            begin
                res.stop_motor   = 1'b1;
                res.zero_encoder = 1'b1;
                target_next      = '0;
                active_next      = 1'b0;
                pending_next     = 1'b0;
                win_steps_next   = '0;
                rev_total_next   = '0;
                reached_next     = 1'b1;
                fault_next       = FAULT_NONE;
            end
            default:
            begin
                // unused modes only report status
            end
        endcase

        res.on_target   = reached_next;
        res.loop_active = active_next;
        res.fault_code  = fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_dir_level <= 1'b0;
            cfg_reg.tolerance     <= TOL_W'(TOL_RESET);
            target_reg            <= '0;
            active_reg            <= 1'b0;
            reached_reg           <= 1'b1;
            fault_reg             <= FAULT_NONE;
            settle_reg            <= '0;
            pending_reg           <= 1'b0;
            exp_dir_reg           <= DIR_NONE;
            win_steps_reg         <= '0;
            rev_total_reg         <= '0;
            win_start_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_POS_DIR:
                begin
                    cfg_reg.pos_dir_level <= cfg_wdata[0];
                    rev_total_reg         <= '0;
                end
                CFG_TOLERANCE:
                begin
                    cfg_reg.tolerance <= cfg_wdata[TOL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (commit)
        begin
            target_reg    <= target_next;
            active_reg    <= active_next;
            reached_reg   <= reached_next;
            fault_reg     <= fault_next;
            settle_reg    <= settle_next;
            pending_reg   <= pending_next;
            exp_dir_reg   <= exp_dir_next;
            win_steps_reg <= win_steps_next;
            rev_total_reg <= rev_total_next;
            win_start_reg <= win_start_next;
        end
    end

endmodule

/* src/spl_out_stage.sv */
// spl_out_stage: result register that drives the result channel
// depends on spl_pkg and spl_out_if

module spl_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    spl_out_if.source          result,
    input  logic               load,
    input  spl_pkg::out_item_t res,
    output logic               can_load
);
    import spl_pkg::*;

    logic      valid_reg;
    out_item_t data_reg;

    assign can_load     = !valid_reg || result.ready;
    assign result.valid = valid_reg;
    assign result.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule

/* src/spl_checker.sv */
// spl_checker: port-level checks on result items of stepper_position_loop
// depends on spl_pkg; bound to the top level at the end of this file

module spl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input spl_pkg::out_item_t res_data
);
    import spl_pkg::*;

    // a stalled result item holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result item changed while stalled");

    // a burst carries a step count and rate and only with a running loop
    a_burst_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.start_burst |->
            res_data.burst_steps != 8'd0 && res_data.step_rate_hz != 13'd0 &&
            !res_data.stop_motor && res_data.loop_active &&
            res_data.fault_code == FAULT_NONE)
        else $error("burst item inconsistent with loop status");

    // no burst means empty burst fields
    a_no_burst: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.start_burst |->
            res_data.burst_steps == 8'd0 && res_data.step_rate_hz == 13'd0 &&
            !res_data.dir_level)
        else $error("burst fields set without a burst");

    // a fault always leaves the loop inactive
    a_fault_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.fault_code != FAULT_NONE |-> !res_data.loop_active)
        else $error("loop active while faulted");

    // zeroing stops the motor and leaves a clean, settled loop
    a_zero_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.zero_encoder |->
            res_data.stop_motor && res_data.on_target && !res_data.loop_active &&
            res_data.fault_code == FAULT_NONE)
        else $error("set zero item inconsistent");

endmodule

bind stepper_position_loop spl_checker u_spl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);
